// ===== hw/rtl/spp_pkg.sv =====
// Shared types and constants for the scaled pixel packer.
`default_nettype none

package spp_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_X_STEP       = 3'd0,
    REG_Y_STEP       = 3'd1,
    REG_X_OFFSET     = 3'd2,
    REG_Y_OFFSET     = 3'd3,
    REG_SOURCE_WIDTH = 3'd4,
    REG_OUT_WIDTH    = 3'd5,
    REG_OUT_HEIGHT   = 3'd6,
    REG_PACKING      = 3'd7
  } cfg_reg_e;

  // Word layouts.
  typedef enum logic [1:0] {
    PACK_HORIZ = 2'd0,  // 4 pixels per byte along a row
    PACK_VERT  = 2'd1,  // 4 pixels per byte down a column
    PACK_PLANE = 2'd2   // 8 rows per 16-bit word, two bit planes
  } pack_e;

  localparam int unsigned CfgDataW   = 20;
  localparam int unsigned AccW       = 28;   // 256 steps of at most 20 bits
  localparam logic [19:0] StepOne    = 20'h10000;
  localparam int unsigned MaxSrcWidth = 512;
  localparam int unsigned MaxOutHeight = 256;
  localparam logic [9:0]  SrcRowMax  = 10'd1023;

  // Payload of the store/merge stage.
  typedef struct packed {
    logic        vert;   // column store read-modify-write
    logic        emit;   // produces a word
    logic        done;   // last word of the frame
    logic        fresh;  // first row of a group: ignore stored bits
    logic        mask8;  // byte-wide word
    logic [15:0] bits;   // new bits, already placed
    logic [8:0]  mul_a;  // row or row group
    logic [8:0]  add;    // column or byte index
  } s1_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scaled_pixel_packer.sv =====
// Top level: nearest-neighbour downscaler and 2-bit display word packer.
`default_nettype none

// Source pixels come in raster order, one transfer per clock while in_stall_o
// is low. Each pixel is checked against the next output position given by two
// 12.16 step accumulators plus the crop offsets; selected pixels have their
// 2-bit level packed into framebuffer words (horizontal bytes, vertical bytes,
// or 16-bit interleaved bit planes). The block accepts one pixel every clock
// cycle unless the input is stalled. A pixel is decided in the cycle it is
// accepted; a selected pixel then passes through the store/merge stage, which
// gets the column store's registered read data, merges it and writes it back,
// and the finished word is then loaded into the output register. Input stall
// rises only when a word waits in the output register, the merge stage holds
// another word, and the output side stalls. Back-to-back hits on the same
// column store entry (one output column) are forwarded from the merge stage.
// Column store entries carry valid bits cleared at reset, so no clearing pass
// is needed. Configuration writes take effect on the next cycle and must only
// be made while idle.

module scaled_pixel_packer
  import spp_pkg::*;
#(
  parameter int unsigned MAX_OUT_WIDTH = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // source pixel stream
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [7:0]          pixel_i,
  input  wire logic                frame_start_i,
  // packed word stream
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [15:0]         word_address_o,
  output      logic [15:0]         word_data_o,
  output      logic                frame_done_o
);

  localparam int unsigned IdxW  = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  // out_width is a 9-bit register, so the cap cannot exceed 511
  localparam int unsigned OwCap = (MAX_OUT_WIDTH > 511) ? 511 : MAX_OUT_WIDTH;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [19:0] x_step_q, y_step_q;
  logic [8:0]  x_offset_q, y_offset_q;
  logic [9:0]  source_width_q;
  logic [8:0]  out_width_q, out_height_q;
  pack_e       packing_q;

  logic [19:0] cfg_step;
  logic [9:0]  cfg_sw;
  logic [8:0]  cfg_ow, cfg_oh;

  always_comb begin
    cfg_step = (cfg_data_i[19:0] < StepOne) ? StepOne : cfg_data_i[19:0];

    if (cfg_data_i[9:0] == 10'd0) begin
      cfg_sw = 10'd1;
    end else if (int'(cfg_data_i[9:0]) > MaxSrcWidth) begin
      cfg_sw = 10'(MaxSrcWidth);
    end else begin
      cfg_sw = cfg_data_i[9:0];
    end

    if (cfg_data_i[8:0] == 9'd0) begin
      cfg_ow = 9'd1;
    end else if (int'(cfg_data_i[8:0]) > OwCap) begin
      cfg_ow = 9'(OwCap);
    end else begin
      cfg_ow = cfg_data_i[8:0];
    end

    if (cfg_data_i[8:0] == 9'd0) begin
      cfg_oh = 9'd1;
    end else if (int'(cfg_data_i[8:0]) > MaxOutHeight) begin
      cfg_oh = 9'(MaxOutHeight);
    end else begin
      cfg_oh = cfg_data_i[8:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_step_q       <= StepOne;
      y_step_q       <= StepOne;
      x_offset_q     <= 9'd0;
      y_offset_q     <= 9'd0;
      source_width_q <= 10'd320;
      out_width_q    <= 9'd160;
      out_height_q   <= 9'd128;
      packing_q      <= PACK_HORIZ;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_X_STEP:       x_step_q       <= cfg_step;
        REG_Y_STEP:       y_step_q       <= cfg_step;
        REG_X_OFFSET:     x_offset_q     <= cfg_data_i[8:0];
        REG_Y_OFFSET:     y_offset_q     <= cfg_data_i[8:0];
        REG_SOURCE_WIDTH: source_width_q <= cfg_sw;
        REG_OUT_WIDTH:    out_width_q    <= cfg_ow;
        REG_OUT_HEIGHT:   out_height_q   <= cfg_oh;
        REG_PACKING: begin
          // code 3 has no layout; keep the old one
          if (cfg_data_i[1:0] != 2'd3) packing_q <= pack_e'(cfg_data_i[1:0]);
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Position counters
  // ---------------------------------------------------------------------
  logic [9:0]      src_col_q, src_col_d, src_row_q, src_row_d;
  logic [AccW-1:0] x_accum_q, x_accum_d, y_accum_q, y_accum_d;
  logic [8:0]      out_col_q, out_col_d, out_row_q, out_row_d;
  logic [7:0]      row_pack_q, row_pack_d;

  // merge stage and output register
  logic        s1_valid_q, s1_valid_d;
  s1_t         s1_q, s1_d;
  logic [IdxW-1:0] s1_idx_q, idx0;
  logic        fwd_q, fwd_d;
  logic [15:0] fwd_data_q;
  logic [15:0] rdata_q;
  logic        s1_vld_q;
  logic        out_valid_q;
  logic [15:0] word_address_q, word_data_q;
  logic        frame_done_q;

  logic s1_adv, accept, out_load, mem_we;

  // stage 0 decode
  logic [9:0]      src_col_c, src_row_c;
  logic [AccW-1:0] x_accum_c, y_accum_c;
  logic [8:0]      out_col_c, out_row_c, out_col_a;
  logic [7:0]      row_pack_c, row_pack_m, row_pack_a;
  logic [12:0]     row_tgt, col_tgt;
  logic            row_wanted, row_end, hit, last_x, last_y;
  logic            horiz, vert, h_emit, flush;
  logic [1:0]      level;
  logic [2:0]      ph;
  logic [2:0]      hsh;

  always_comb begin
    src_col_c  = frame_start_i ? 10'd0 : src_col_q;
    src_row_c  = frame_start_i ? 10'd0 : src_row_q;
    x_accum_c  = frame_start_i ? '0 : x_accum_q;
    y_accum_c  = frame_start_i ? '0 : y_accum_q;
    out_col_c  = frame_start_i ? 9'd0 : out_col_q;
    out_row_c  = frame_start_i ? 9'd0 : out_row_q;
    row_pack_c = frame_start_i ? 8'd0 : row_pack_q;

    level = pixel_i[1:0];
    ph    = out_row_c[2:0];

    row_tgt    = 13'(y_offset_q) + 13'(y_accum_c[AccW-1:16]);
    col_tgt    = 13'(x_offset_q) + 13'(x_accum_c[AccW-1:16]);
    row_wanted = (out_row_c < out_height_q) && (13'(src_row_c) == row_tgt);
    row_end    = (11'(src_col_c) + 11'd1) >= 11'(source_width_q);
    hit        = row_wanted && (out_col_c < out_width_q) && (13'(src_col_c) == col_tgt);
    last_x     = out_col_c == (out_width_q - 9'd1);
    last_y     = out_row_c == (out_height_q - 9'd1);

    horiz = packing_q == PACK_HORIZ;
    vert  = hit && !horiz;

    // leftmost pixel lands in bits 7:6
    hsh        = {~out_col_c[1:0], 1'b0};
    row_pack_m = ((out_col_c[1:0] == 2'd0) ? 8'd0 : row_pack_c) | (8'(level) << hsh);
    h_emit     = hit && horiz && ((out_col_c[1:0] == 2'd3) || last_x);
    out_col_a  = out_col_c + 9'(hit);
    row_pack_a = (hit && horiz) ? row_pack_m : row_pack_c;
    // partly filled byte at the end of the source row
    flush      = row_end && row_wanted && horiz && !h_emit &&
                 (out_col_a < out_width_q) && (out_col_a[1:0] != 2'd0);

    // stage 1 payload
    s1_d       = '0;
    s1_d.vert  = vert;
    s1_d.mask8 = packing_q != PACK_PLANE;
    if (vert) begin
      s1_d.done = last_x && last_y;
      s1_d.add  = out_col_c;
      if (packing_q == PACK_VERT) begin
        s1_d.emit  = (ph[1:0] == 2'd3) || last_y;
        s1_d.fresh = ph[1:0] == 2'd0;
        s1_d.bits  = 16'(level) << {ph[1:0], 1'b0};
        s1_d.mul_a = out_row_c >> 2;
      end else begin
        s1_d.emit  = (ph == 3'd7) || last_y;
        s1_d.fresh = ph == 3'd0;
        s1_d.bits  = (16'(level[0]) << ph) | (16'(level[1]) << (4'(ph) + 4'd8));
        s1_d.mul_a = out_row_c >> 3;
      end
    end else begin
      s1_d.emit  = h_emit || flush;
      s1_d.done  = h_emit ? (last_x && last_y) : last_y;
      s1_d.fresh = 1'b1;
      s1_d.bits  = {8'd0, row_pack_a};
      s1_d.mul_a = out_row_c;
      s1_d.add   = h_emit ? (out_col_c >> 2) : ((out_col_a - 9'd1) >> 2);
    end
    s1_valid_d = accept && (vert || s1_d.emit);
    idx0       = IdxW'(out_col_c);

    // counter updates
    src_col_d  = row_end ? 10'd0 : src_col_c + 10'd1;
    src_row_d  = (row_end && (src_row_c != SrcRowMax)) ? src_row_c + 10'd1 : src_row_c;
    out_col_d  = out_col_a;
    x_accum_d  = hit ? x_accum_c + AccW'(x_step_q) : x_accum_c;
    out_row_d  = out_row_c;
    y_accum_d  = y_accum_c;
    row_pack_d = row_pack_a;
    if (row_end && row_wanted) begin
      out_row_d  = out_row_c + 9'd1;
      y_accum_d  = y_accum_c + AccW'(y_step_q);
      out_col_d  = 9'd0;
      x_accum_d  = '0;
      row_pack_d = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q  <= 10'd0;
      src_row_q  <= 10'd0;
      x_accum_q  <= '0;
      y_accum_q  <= '0;
      out_col_q  <= 9'd0;
      out_row_q  <= 9'd0;
      row_pack_q <= 8'd0;
    end else if (accept) begin
      src_col_q  <= src_col_d;
      src_row_q  <= src_row_d;
      x_accum_q  <= x_accum_d;
      y_accum_q  <= y_accum_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      row_pack_q <= row_pack_d;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: merge stage drains unless it holds a word the output
  // register cannot take.
  // ---------------------------------------------------------------------
  assign s1_adv     = !s1_valid_q || !s1_q.emit || !out_valid_q || !out_stall_i;
  assign accept     = in_valid_i && s1_adv;
  assign in_stall_o = !s1_adv;
  assign out_load   = s1_adv && s1_valid_q && s1_q.emit;
  assign mem_we     = s1_adv && s1_valid_q && s1_q.vert;

  // ---------------------------------------------------------------------
  // Merge stage: combine new bits with stored column bits, form address
  // ---------------------------------------------------------------------
  logic [15:0] old_bits, merged, s1_wdata;
  logic [7:0]  bytes_per_row;
  logic [8:0]  mul_b;
  logic [17:0] addr_full;

  always_comb begin
    if (s1_q.fresh) begin
      old_bits = 16'd0;
    end else if (fwd_q) begin
      old_bits = fwd_data_q;
    end else if (s1_vld_q) begin
      old_bits = rdata_q;
    end else begin
      old_bits = 16'd0;
    end
    merged   = old_bits | s1_q.bits;
    s1_wdata = s1_q.mask8 ? {8'd0, merged[7:0]} : merged;

    bytes_per_row = 8'((10'(out_width_q) + 10'd3) >> 2);
    mul_b         = s1_q.vert ? out_width_q : 9'(bytes_per_row);
    addr_full     = (18'(s1_q.mul_a) * 18'(mul_b)) + 18'(s1_q.add);
  end

  // same entry written by the leaving item and read by the arriving one
  assign fwd_d = accept && vert && s1_valid_q && s1_q.vert && (s1_idx_q == idx0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= s1_valid_d;
      fwd_q      <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q       <= s1_d;
      s1_idx_q   <= idx0;
      fwd_data_q <= s1_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Column store: one write port (merge stage), one registered read port
  // ---------------------------------------------------------------------
  logic [15:0]              col_mem [MAX_OUT_WIDTH];
  logic [MAX_OUT_WIDTH-1:0] col_vld_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) col_mem[s1_idx_q] <= s1_wdata;
    if (accept) rdata_q <= col_mem[idx0];
  end

  // unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_vld_q <= '0;
      s1_vld_q  <= 1'b0;
    end else begin
      if (mem_we) col_vld_q[s1_idx_q] <= 1'b1;
      if (accept) s1_vld_q <= col_vld_q[idx0];
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      word_address_q <= addr_full[15:0];
      word_data_q    <= s1_wdata;
      frame_done_q   <= s1_q.done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign word_address_o = word_address_q;
  assign word_data_o    = word_data_q;
  assign frame_done_o   = frame_done_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with empty merge stage");

  a_fwd_vert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (s1_valid_q && s1_q.vert))
    else $error("forward flag without column store access");

  a_horiz_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_q.vert) |-> s1_q.emit)
    else $error("horizontal item in merge stage without a word");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && frame_start_i) |=> (src_row_q <= 10'd1 && out_row_q <= 9'd1))
    else $error("counters not restarted by frame start");

endmodule

`default_nettype wire
